[rtl/sdspi_pkg.sv]
// Shared types, codes and command tables for the SD card SPI-mode sequencer.
// No dependencies; the core, sdspi_seq and the bench import this package.
package sdspi_pkg;

    localparam logic [2:0] ACT_INIT  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_LOAD  = 3'd3;
    localparam logic [2:0] ACT_CARD  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_RESET   = 3'd1;
    localparam logic [2:0] ST_IDLE_ERR   = 3'd2;
    localparam logic [2:0] ST_R7_BAD     = 3'd3;
    localparam logic [2:0] ST_OCR_ERR    = 3'd4;
    localparam logic [2:0] ST_WCMD_REJ   = 3'd5;
    localparam logic [2:0] ST_DATA_REJ   = 3'd6;
    localparam logic [2:0] ST_RCMD_REJ   = 3'd7;

    localparam logic [2:0] REG_BLOCK_ADDR = 3'd0;
    localparam logic [2:0] REG_PAY_LEN    = 3'd1;
    localparam logic [2:0] REG_RESP_TRIES = 3'd2;
    localparam logic [2:0] REG_WACC_TRIES = 3'd3;
    localparam logic [2:0] REG_DUMMY      = 3'd4;

    localparam logic [7:0] BYTE_IDLE   = 8'hFF;
    localparam logic [7:0] TOKEN_START = 8'hFE;
    localparam logic [7:0] R7_ECHO     = 8'hAA;
    localparam logic [7:0] R7_VOLT     = 8'h01;
    localparam logic [4:0] DRESP_MASK  = 5'h1F;
    localparam logic [4:0] DRESP_OK    = 5'h05;

    typedef enum logic [2:0] {
        CMD_0, CMD_55A, CMD_8, CMD_55L, CMD_41, CMD_58, CMD_24, CMD_17
    } cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] rx_byte;
        logic [6:0] payload_index;
        logic [7:0] payload_value;
    } in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_level;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [6:0] read_index;
        logic       done_res;
        logic [2:0] status;
    } out_t;

    typedef struct packed {
        logic [31:0] block_address;
        logic [7:0]  payload_length;
        logic [7:0]  response_tries;
        logic [7:0]  write_accept_tries;
        logic [4:0]  dummy_bytes;
    } cfg_t;

    function automatic logic [7:0] cmd_byte(input cmd_t c, input logic [2:0] idx,
                                            input logic [31:0] addr);
        logic [31:0] arg;
        logic [7:0]  code;
        logic [7:0]  crc;
        arg  = 32'h0;
        code = 8'h40;
        crc  = 8'h01;
        case (c)
            CMD_0:   begin code = 8'h40; crc = 8'h95; end
            CMD_55A: begin code = 8'h77; end
            CMD_8:   begin code = 8'h48; crc = 8'h87; arg = 32'h0000_01AA; end
            CMD_55L: begin code = 8'h77; end
            CMD_41:  begin code = 8'h69; arg = 32'h4000_0000; end
            CMD_58:  begin code = 8'h7A; end
            CMD_24:  begin code = 8'h58; crc = 8'hFF; arg = addr; end
            default: begin code = 8'h51; crc = 8'h00; arg = addr; end
        endcase
        case (idx)
            3'd0:    return code;
            3'd1:    return arg[31:24];
            3'd2:    return arg[23:16];
            3'd3:    return arg[15:8];
            3'd4:    return arg[7:0];
            default: return crc;
        endcase
    endfunction

endpackage

[rtl/sd_spi_card_sequencer_core.sv]
// SD card SPI-mode sequencer: takes start, payload-load and card-byte beats and
// returns one result beat per start or per card byte in a sequence, giving the
// next byte to send or the final status. Each item passes an input register and
// one pass of sequencing logic into the result register; that single registered
// pass takes one item every cycle unless the output stalls. The payload memory
// has a registered read port, read as the result is formed. Uses sdspi_pkg.
module sd_spi_card_sequencer_core
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = 512,
    parameter int PAYLOAD_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int CW0 = $clog2(BLOCK_BYTES + 3);
    localparam int CW  = (CW0 > 9) ? CW0 : 9;
    localparam int AW  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    cfg_t          cfg_reg;
    logic          iv_reg;
    in_t           in_reg;
    logic          ov_reg;
    out_t          out_reg;
    logic          mem_sel_reg;
    logic          go;
    logic          proc;
    out_t          result;
    logic          has_result;
    logic          use_mem;
    logic [CW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          load_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_address      <= 32'd512;
            cfg_reg.payload_length     <= 8'd100;
            cfg_reg.response_tries     <= 8'd100;
            cfg_reg.write_accept_tries <= 8'd8;
            cfg_reg.dummy_bytes        <= 5'd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BLOCK_ADDR: cfg_reg.block_address      <= cfg_data;
                REG_PAY_LEN:    cfg_reg.payload_length     <= cfg_data[7:0];
                REG_RESP_TRIES: cfg_reg.response_tries     <= cfg_data[7:0];
                REG_WACC_TRIES: cfg_reg.write_accept_tries <= cfg_data[7:0];
                REG_DUMMY:      cfg_reg.dummy_bytes        <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // The held beat advances whenever the result register is free or drains.
    assign go       = iv_reg && (!ov_reg || !out_stall);
    assign in_stall = iv_reg && !go;
    assign proc     = go && has_result;
    assign load_en  = go && (in_reg.action == ACT_LOAD)
                      && (int'(in_reg.payload_index) < PAYLOAD_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                iv_reg <= in_valid;
            end
            if (go)
            begin
                ov_reg <= has_result;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_reg <= in_data;
        end
        if (proc)
        begin
            out_reg     <= result;
            mem_sel_reg <= use_mem;
        end
    end

    sdspi_seq #(
        .BLOCK_BYTES   (BLOCK_BYTES),
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .CW            (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .item       (in_reg),
        .cfg        (cfg_reg),
        .result     (result),
        .has_result (has_result),
        .use_mem    (use_mem),
        .rd_addr    (rd_addr)
    );

    sdspi_payload_mem #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .AW            (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (AW'(in_reg.payload_index)),
        .wr_data (in_reg.payload_value),
        .rd_en   (proc),
        .rd_addr (rd_addr[AW-1:0]),
        .rd_data (rd_data)
    );

    assign out_valid = ov_reg;

    always_comb
    begin
        out_data = out_reg;
        if (mem_sel_reg)
        begin
            out_data.tx_byte = rd_data;
        end
    end

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (out_reg.tx_valid != out_reg.done_res))
        else $error("result beat must be either a byte or a status");
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_reg.done_res) |-> out_reg.status == ST_OK)
        else $error("status set without done");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (ov_reg && out_stall))
        else $error("input stalled while result side is free");
    a_memsel: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && mem_sel_reg) |-> out_reg.tx_valid)
        else $error("payload byte chosen for a status beat");
endmodule

[rtl/sdspi_payload_mem.sv]
// Payload buffer: one write port for payload loads, one registered read port.
// Depends on nothing but its parameters.
module sdspi_payload_mem #(
    parameter int PAYLOAD_DEPTH = 128,
    parameter int AW = 7
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [PAYLOAD_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

[rtl/sdspi_seq.sv]
// Sequence state and per-beat next-state/result logic of the SD SPI sequencer.
// Uses sdspi_pkg; the payload read data is merged in at the top level.
module sdspi_seq
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = 512,
    parameter int PAYLOAD_DEPTH = 128,
    parameter int CW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  in_t           item,
    input  cfg_t          cfg,
    output out_t          result,
    output logic          has_result,
    output logic          use_mem,
    output logic [CW-1:0] rd_addr
);
    localparam int LEN_LIM = (PAYLOAD_DEPTH < BLOCK_BYTES) ? PAYLOAD_DEPTH : BLOCK_BYTES;
    localparam logic [CW-1:0] BB      = CW'(BLOCK_BYTES);
    localparam logic [CW-1:0] BB_CRC  = CW'(BLOCK_BYTES + 2);

    typedef enum logic [13:0] {
        PH_IDLE   = 14'b00000000000001,
        PH_DUMMY  = 14'b00000000000010,
        PH_CMD    = 14'b00000000000100,
        PH_RESP   = 14'b00000000001000,
        PH_R7     = 14'b00000000010000,
        PH_EXTRA  = 14'b00000000100000,
        PH_PRE_W  = 14'b00000001000000,
        PH_PRE_R  = 14'b00000010000000,
        PH_TOKEN  = 14'b00000100000000,
        PH_WDATA  = 14'b00001000000000,
        PH_DRESP  = 14'b00010000000000,
        PH_BUSY   = 14'b00100000000000,
        PH_RTOKEN = 14'b01000000000000,
        PH_RDATA  = 14'b10000000000000
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [CW-1:0] bc_reg, bc_next;
    logic [7:0]    try_reg, try_next;
    logic [2:0]    cbi_reg, cbi_next;
    logic          sel_reg, sel_next;
    logic          echo_reg, echo_next;
    logic          r8nz_reg, r8nz_next;
    cmd_t          cmd_reg, cmd_next;

    logic [CW-1:0] eff_len;
    logic [CW-1:0] bc_inc;
    logic [8:0]    try_inc;
    logic [7:0]    tries_now;
    logic          ended;
    logic [2:0]    st;
    logic          rv;
    logic          rx_idle;

    always_comb
    begin
        if (int'(cfg.payload_length) > LEN_LIM)
        begin
            eff_len = CW'(LEN_LIM);
        end
        else
        begin
            eff_len = CW'(cfg.payload_length);
        end
    end

    assign bc_inc    = bc_reg + 1'b1;
    assign try_inc   = {1'b0, try_reg} + 9'd1;
    assign tries_now = (cmd_reg == CMD_24) ? cfg.write_accept_tries : cfg.response_tries;
    assign rx_idle   = (item.rx_byte == BYTE_IDLE);

    always_comb
    begin
        phase_next = phase_reg;
        bc_next    = bc_reg;
        try_next   = try_reg;
        cbi_next   = cbi_reg;
        sel_next   = sel_reg;
        echo_next  = echo_reg;
        r8nz_next  = r8nz_reg;
        cmd_next   = cmd_reg;
        ended      = 1'b0;
        st         = ST_OK;
        rv         = 1'b0;
        has_result = 1'b0;

        case (item.action)
            ACT_INIT:
            begin
                has_result = 1'b1;
                sel_next   = 1'b1;
                bc_next    = '0;
                phase_next = PH_DUMMY;
            end
            ACT_WRITE:
            begin
                has_result = 1'b1;
                sel_next   = 1'b0;
                phase_next = PH_PRE_W;
            end
            ACT_READ:
            begin
                has_result = 1'b1;
                sel_next   = 1'b0;
                phase_next = PH_PRE_R;
            end
            ACT_CARD:
            begin
                has_result = (phase_reg != PH_IDLE);
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_DUMMY:
                    begin
                        bc_next = bc_inc;
                        if (bc_inc >= CW'(cfg.dummy_bytes))
                        begin
                            sel_next   = 1'b0;
                            cmd_next   = CMD_0;
                            cbi_next   = '0;
                            phase_next = PH_CMD;
                        end
                    end
                    PH_CMD:
                    begin
                        cbi_next = cbi_reg + 1'b1;
                        if (cbi_reg == 3'd5)
                        begin
                            try_next   = '0;
                            phase_next = PH_RESP;
                        end
                    end
                    PH_RESP:
                    begin
                        try_next = try_inc[7:0];
                        if (!rx_idle || try_inc >= {1'b0, tries_now})
                        begin
                            cbi_next   = '0;
                            phase_next = PH_CMD;
                            case (cmd_reg)
                                CMD_0:
                                begin
                                    if (rx_idle)
                                    begin
                                        ended = 1'b1;
                                        st    = ST_NO_RESET;
                                    end
                                    cmd_next = CMD_55A;
                                end
                                CMD_55A:
                                begin
                                    if (item.rx_byte > 8'd1)
                                    begin
                                        ended = 1'b1;
                                        st    = ST_IDLE_ERR;
                                    end
                                    cmd_next = CMD_8;
                                end
                                CMD_8:
                                begin
                                    r8nz_next  = (item.rx_byte != 8'd0);
                                    bc_next    = '0;
                                    phase_next = PH_R7;
                                end
                                CMD_55L: cmd_next = CMD_41;
                                CMD_41:
                                    cmd_next = (item.rx_byte == 8'd0) ? CMD_58 : CMD_55L;
                                CMD_58:
                                begin
                                    echo_next  = (item.rx_byte == 8'd0);
                                    bc_next    = '0;
                                    try_next   = '0;
                                    phase_next = PH_EXTRA;
                                end
                                CMD_24:
                                begin
                                    if (item.rx_byte != 8'd0)
                                    begin
                                        ended = 1'b1;
                                        st    = ST_WCMD_REJ;
                                    end
                                    phase_next = PH_TOKEN;
                                end
                                default:
                                begin
                                    if (item.rx_byte != 8'd0)
                                    begin
                                        ended = 1'b1;
                                        st    = ST_RCMD_REJ;
                                    end
                                    phase_next = PH_RTOKEN;
                                end
                            endcase
                        end
                    end
                    PH_R7:
                    begin
                        if (bc_reg == CW'(2))
                        begin
                            echo_next = (item.rx_byte == R7_VOLT);
                        end
                        if (bc_reg >= CW'(3))
                        begin
                            if (!(echo_reg && item.rx_byte == R7_ECHO))
                            begin
                                ended = 1'b1;
                                st    = ST_R7_BAD;
                            end
                            cmd_next   = r8nz_reg ? CMD_55L : CMD_58;
                            cbi_next   = '0;
                            phase_next = PH_CMD;
                        end
                        else
                        begin
                            bc_next = bc_inc;
                        end
                    end
                    PH_EXTRA:
                    begin
                        try_next = try_inc[7:0];
                        if (!rx_idle || try_inc >= {1'b0, cfg.response_tries})
                        begin
                            try_next = '0;
                            bc_next  = bc_inc;
                            if (bc_inc >= CW'(4))
                            begin
                                sel_next = 1'b1;
                                ended    = 1'b1;
                                st       = echo_reg ? ST_OK : ST_OCR_ERR;
                            end
                        end
                    end
                    PH_PRE_W:
                    begin
                        cmd_next   = CMD_24;
                        cbi_next   = '0;
                        phase_next = PH_CMD;
                    end
                    PH_PRE_R:
                    begin
                        cmd_next   = CMD_17;
                        cbi_next   = '0;
                        phase_next = PH_CMD;
                    end
                    PH_TOKEN:
                    begin
                        bc_next    = '0;
                        phase_next = PH_WDATA;
                    end
                    PH_WDATA:
                    begin
                        bc_next = bc_inc;
                        if (bc_inc >= BB_CRC)
                        begin
                            try_next   = '0;
                            phase_next = PH_DRESP;
                        end
                    end
                    PH_DRESP:
                    begin
                        try_next = try_inc[7:0];
                        if (!rx_idle || try_inc >= {1'b0, cfg.response_tries})
                        begin
                            if ((item.rx_byte[4:0] & DRESP_MASK) != DRESP_OK)
                            begin
                                ended = 1'b1;
                                st    = ST_DATA_REJ;
                            end
                            phase_next = PH_BUSY;
                        end
                    end
                    PH_BUSY:
                    begin
                        if (rx_idle)
                        begin
                            sel_next = 1'b1;
                            ended    = 1'b1;
                        end
                    end
                    PH_RTOKEN:
                    begin
                        if (item.rx_byte == TOKEN_START)
                        begin
                            bc_next    = '0;
                            phase_next = PH_RDATA;
                        end
                    end
                    PH_RDATA:
                    begin
                        rv      = (bc_reg < eff_len);
                        bc_next = bc_inc;
                        if (bc_inc >= BB_CRC)
                        begin
                            phase_next = PH_BUSY;
                        end
                    end
                    default: ;
                endcase
                if (ended)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    // Result beat, built from the state this item leaves behind.
    always_comb
    begin
        result              = '0;
        use_mem             = 1'b0;
        rd_addr             = bc_next;
        result.select_level = sel_next;
        if (rv)
        begin
            result.read_valid = 1'b1;
            result.read_byte  = item.rx_byte;
            result.read_index = bc_reg[6:0];
        end
        if (ended)
        begin
            result.done_res = 1'b1;
            result.status   = st;
        end
        else
        begin
            result.tx_valid = 1'b1;
            unique case (phase_next)
                PH_CMD:   result.tx_byte = cmd_byte(cmd_next, cbi_next, cfg.block_address);
                PH_TOKEN: result.tx_byte = TOKEN_START;
                PH_WDATA:
                begin
                    if (bc_next < eff_len)
                    begin
                        use_mem = 1'b1;
                    end
                    else if (bc_next < BB)
                    begin
                        result.tx_byte = BYTE_IDLE;
                    end
                end
                default:  result.tx_byte = BYTE_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bc_reg    <= '0;
            try_reg   <= '0;
            cbi_reg   <= '0;
            sel_reg   <= 1'b1;
            echo_reg  <= 1'b0;
            r8nz_reg  <= 1'b0;
            cmd_reg   <= CMD_0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            try_reg   <= try_next;
            cbi_reg   <= cbi_next;
            sel_reg   <= sel_next;
            echo_reg  <= echo_next;
            r8nz_reg  <= r8nz_next;
            cmd_reg   <= cmd_next;
        end
    end

    a_cmd_idx: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CMD |-> cbi_reg <= 3'd5)
        else $error("command byte index out of range");
    a_bc_range: assert property (@(posedge clk) disable iff (!rst_n)
        bc_reg <= BB_CRC)
        else $error("byte counter out of range");
    a_idle_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DUMMY) |-> sel_reg)
        else $error("card selected during dummy clocks");
endmodule

[bench/testbench.sv]
// Self-checking bench for sd_spi_card_sequencer_core: a card responder drives init, write and
// read sequences under random gaps and stalls, and a scoreboard predicts every result beat.
// Depends on sdspi_pkg and the core RTL only.
module testbench;
    import sdspi_pkg::*;

    localparam int BLK = 512;
    localparam int DEPTH = 128;
    localparam int LIMIT = 600000;

    typedef enum int {
        P_IDLE, P_DUMMY, P_CMD, P_RESP, P_R7, P_EXTRA, P_PREW, P_PRER,
        P_TOKEN, P_WDATA, P_DRESP, P_BUSY, P_RTOKEN, P_RDATA
    } seq_phase_t;

    class sd_scoreboard;
        logic [31:0] addr = 32'd512;
        int len = 100, rtries = 100, wtries = 8, dummies = 10;
        seq_phase_t ph = P_IDLE;
        int cnt = 0, tries = 0, cbi = 0;
        bit sel = 1, echo = 0;
        cmd_t cmd = CMD_0;
        logic [7:0] cmd8_r1 = 8'h00;
        logic [7:0] store [DEPTH];
        out_t pending[$];
        int errors = 0, checked = 0;

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h want %0h (beat %0d)", what, got, want, checked);
            errors++;
        endtask

        function int eff_len();
            return (len > DEPTH) ? DEPTH : len;
        endfunction

        function void begin_cmd(cmd_t c);
            cmd = c;
            cbi = 0;
            ph = P_CMD;
        endfunction

        function logic [7:0] next_tx();
            logic [31:0] arg;
            logic [7:0] code, crc;
            arg = 32'h0;
            crc = 8'h01;
            code = 8'h40;
            case (cmd)
                CMD_0:   crc = 8'h95;
                CMD_55A, CMD_55L: code = 8'h40 | 8'd55;
                CMD_8:   begin code = 8'h40 | 8'd8; crc = 8'h87; arg = 32'h1AA; end
                CMD_41:  begin code = 8'h40 | 8'd41; arg = 32'h4000_0000; end
                CMD_58:  code = 8'h40 | 8'd58;
                CMD_24:  begin code = 8'h40 | 8'd24; crc = 8'hFF; arg = addr; end
                default: begin code = 8'h40 | 8'd17; crc = 8'h00; arg = addr; end
            endcase
            case (ph)
                P_CMD:
                    case (cbi)
                        0: return code;
                        1: return arg[31:24];
                        2: return arg[23:16];
                        3: return arg[15:8];
                        4: return arg[7:0];
                        default: return crc;
                    endcase
                P_TOKEN: return TOKEN_START;
                P_WDATA:
                    if (cnt < eff_len()) return store[cnt];
                    else if (cnt < BLK) return BYTE_IDLE;
                    else return 8'h00;
                default: return BYTE_IDLE;
            endcase
        endfunction

        // Handles the reply byte of a finished response wait; -1 means keep going.
        function int on_reply(logic [7:0] r1);
            case (cmd)
                CMD_0: begin if (r1 == BYTE_IDLE) return ST_NO_RESET; begin_cmd(CMD_55A); end
                CMD_55A: begin if (r1 > 8'd1) return ST_IDLE_ERR; begin_cmd(CMD_8); end
                CMD_8: begin cmd8_r1 = r1; cnt = 0; ph = P_R7; end
                CMD_55L: begin_cmd(CMD_41);
                CMD_41: begin_cmd(r1 == 8'd0 ? CMD_58 : CMD_55L);
                CMD_58: begin echo = (r1 == 8'd0); cnt = 0; tries = 0; ph = P_EXTRA; end
                CMD_24: begin if (r1 != 8'd0) return ST_WCMD_REJ; ph = P_TOKEN; end
                default: begin if (r1 != 8'd0) return ST_RCMD_REJ; ph = P_RTOKEN; end
            endcase
            return -1;
        endfunction

        function int on_card(logic [7:0] rx, output bit rv, output int ridx);
            int limit;
            rv = 0;
            ridx = 0;
            case (ph)
                P_DUMMY: begin
                    cnt++;
                    if (cnt >= dummies) begin sel = 0; begin_cmd(CMD_0); end
                end
                P_CMD: begin
                    cbi++;
                    if (cbi >= 6) begin tries = 0; ph = P_RESP; end
                end
                P_RESP: begin
                    limit = (cmd == CMD_24) ? wtries : rtries;
                    tries++;
                    if (rx != BYTE_IDLE || tries >= limit) return on_reply(rx);
                end
                P_R7: begin
                    if (cnt == 2) echo = (rx == R7_VOLT);
                    if (cnt >= 3) begin
                        if (!(echo && rx == R7_ECHO)) return ST_R7_BAD;
                        begin_cmd(cmd8_r1 == 8'd0 ? CMD_58 : CMD_55L);
                    end else cnt++;
                end
                P_EXTRA: begin
                    tries++;
                    if (rx != BYTE_IDLE || tries >= rtries) begin
                        tries = 0;
                        cnt++;
                        if (cnt >= 4) begin sel = 1; return echo ? ST_OK : ST_OCR_ERR; end
                    end
                end
                P_PREW: begin_cmd(CMD_24);
                P_PRER: begin_cmd(CMD_17);
                P_TOKEN: begin cnt = 0; ph = P_WDATA; end
                P_WDATA: begin
                    cnt++;
                    if (cnt >= BLK + 2) begin tries = 0; ph = P_DRESP; end
                end
                P_DRESP: begin
                    tries++;
                    if (rx != BYTE_IDLE || tries >= rtries) begin
                        if ((rx[4:0] & DRESP_MASK) != DRESP_OK) return ST_DATA_REJ;
                        ph = P_BUSY;
                    end
                end
                P_BUSY: if (rx == BYTE_IDLE) begin sel = 1; return ST_OK; end
                P_RTOKEN: if (rx == TOKEN_START) begin cnt = 0; ph = P_RDATA; end
                default: begin
                    if (cnt < eff_len()) begin rv = 1; ridx = cnt; end
                    cnt++;
                    if (cnt >= BLK + 2) ph = P_BUSY;
                end
            endcase
            return -1;
        endfunction

        function void note_input(in_t it);
            out_t r;
            int st, ridx;
            bit rv;
            st = -1;
            rv = 0;
            ridx = 0;
            case (it.action)
                ACT_LOAD: begin store[it.payload_index] = it.payload_value; return; end
                ACT_INIT: begin sel = 1; cnt = 0; ph = P_DUMMY; end
                ACT_WRITE: begin sel = 0; ph = P_PREW; end
                ACT_READ: begin sel = 0; ph = P_PRER; end
                ACT_CARD: begin
                    if (ph == P_IDLE) return;
                    st = on_card(it.rx_byte, rv, ridx);
                end
                default: return;
            endcase
            r = '0;
            if (st >= 0) begin
                ph = P_IDLE;
                r.done_res = 1;
                r.status = st[2:0];
            end else begin
                r.tx_valid = 1;
                r.tx_byte = next_tx();
            end
            r.select_level = sel;
            if (rv) begin
                r.read_valid = 1;
                r.read_byte = it.rx_byte;
                r.read_index = ridx[6:0];
            end
            pending.push_back(r);
        endfunction

        task check_result(out_t got);
            out_t want;
            if (pending.size() == 0) begin
                report("unexpected beat", 32'(got), 32'd0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.tx_valid !== want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
            if (got.tx_byte !== want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
            if (got.select_level !== want.select_level)
                report("select_level", got.select_level, want.select_level);
            if (got.read_valid !== want.read_valid)
                report("read_valid", got.read_valid, want.read_valid);
            if (got.read_byte !== want.read_byte) report("read_byte", got.read_byte, want.read_byte);
            if (got.read_index !== want.read_index)
                report("read_index", got.read_index, want.read_index);
            if (got.done_res !== want.done_res) report("done_res", got.done_res, want.done_res);
            if (got.status !== want.status) report("status", got.status, want.status);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, in_stall;
    in_t in_data = '0;
    logic out_valid, out_stall = 1;
    out_t out_data;
    logic cfg_valid = 0, cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    sd_scoreboard sb = new();
    int cycles = 0;
    int items = 0;
    int sequences = 0;
    bit calm = 0;
    bit clean = 0;

    sd_spi_card_sequencer_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL sd_spi_card_sequencer_core");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Result side: a fresh stall length for every beat.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = calm ? 0 : $urandom_range(6);
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task send(in_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(6);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        sb.note_input(it);
        items++;
        @(negedge clk);
    endtask

    task drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_BLOCK_ADDR: sb.addr = val;
            REG_PAY_LEN:    sb.len = int'(val[7:0]);
            REG_RESP_TRIES: sb.rtries = int'(val[7:0]);
            REG_WACC_TRIES: sb.wtries = int'(val[7:0]);
            default:        sb.dummies = int'(val[4:0]);
        endcase
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    function in_t make(logic [2:0] act, logic [7:0] rx);
        in_t it;
        it.action = act;
        it.rx_byte = rx;
        it.payload_index = 7'($urandom_range(127));
        it.payload_value = 8'($urandom_range(255));
        return it;
    endfunction

    function bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // The card's answer to the byte being sent, mostly well-formed.
    function logic [7:0] card_answer();
        bit bad;
        bad = !clean && chance(4);
        case (sb.ph)
            P_RESP: begin
                if (chance(40)) return BYTE_IDLE;
                if (bad) return 8'($urandom_range(255));
                case (sb.cmd)
                    CMD_0, CMD_55L: return 8'h01;
                    CMD_55A, CMD_8: return 8'($urandom_range(1));
                    CMD_41: return chance(50) ? 8'h00 : 8'h01;
                    default: return 8'h00;
                endcase
            end
            P_R7: begin
                if (bad) return 8'($urandom_range(255));
                if (sb.cnt == 2) return R7_VOLT;
                if (sb.cnt == 3) return R7_ECHO;
                return 8'($urandom_range(255));
            end
            P_EXTRA: return chance(50) ? BYTE_IDLE : 8'($urandom_range(255));
            P_DRESP: begin
                if (chance(40)) return BYTE_IDLE;
                return bad ? 8'h0B : {3'($urandom_range(7)), DRESP_OK};
            end
            P_BUSY: return chance(60) ? 8'h00 : BYTE_IDLE;
            P_RTOKEN: return chance(30) ? TOKEN_START : BYTE_IDLE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task run_sequence(logic [2:0] act);
        sequences++;
        send(make(act, 8'($urandom_range(255))));
        while (sb.ph != P_IDLE)
        begin
            if (!clean && chance(0) == 0 && $urandom_range(999) == 0)
                send(make(3'($urandom_range(2)), 8'h00));
            else if (!clean && chance(2))
                send(make(ACT_LOAD, 8'h00));
            else
                send(make(ACT_CARD, card_answer()));
        end
    endtask

    task noise();
        case ($urandom_range(2))
            0: send(make(ACT_CARD, 8'($urandom_range(255))));
            1: send(make(ACT_LOAD, 8'($urandom_range(255))));
            default: send(make(3'($urandom_range(5, 7)), 8'($urandom_range(255))));
        endcase
    endtask

    initial
    begin
        in_t it;
        int p;
        repeat (2) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Every payload entry is written before any block write can send it.
        calm = 1;
        for (int i = 0; i < DEPTH; i++)
        begin
            it = make(ACT_LOAD, 8'h00);
            it.payload_index = 7'(i);
            send(it);
        end
        calm = 0;

        // Directed: idle card bytes, unknown actions, clean sequences, a start that aborts.
        send(make(ACT_CARD, 8'hFF));
        send(make(3'd5, 8'h00));
        send(make(3'd6, 8'hFF));
        send(make(3'd7, 8'hAA));
        clean = 1;
        run_sequence(ACT_INIT);
        run_sequence(ACT_WRITE);
        run_sequence(ACT_READ);
        clean = 0;
        send(make(ACT_INIT, 8'h00));
        send(make(ACT_CARD, 8'hFF));
        run_sequence(ACT_INIT);

        for (p = 0; p < 6; p++)
        begin
            drain();
            if (p == 1)
            begin
                write_reg(REG_BLOCK_ADDR, 32'h0);
                write_reg(REG_PAY_LEN, 32'd1);
                write_reg(REG_RESP_TRIES, 32'd1);
                write_reg(REG_WACC_TRIES, 32'd1);
                write_reg(REG_DUMMY, 32'd1);
            end
            else if (p == 2)
            begin
                write_reg(REG_BLOCK_ADDR, 32'hFFFF_FFFF);
                write_reg(REG_PAY_LEN, 32'd128);
                write_reg(REG_RESP_TRIES, 32'd255);
                write_reg(REG_WACC_TRIES, 32'd255);
                write_reg(REG_DUMMY, 32'd31);
            end
            else if (p > 2)
            begin
                write_reg(REG_BLOCK_ADDR, $urandom);
                write_reg(REG_PAY_LEN, $urandom_range(1, 128));
                write_reg(REG_RESP_TRIES, $urandom_range(1, 6));
                write_reg(REG_WACC_TRIES, $urandom_range(1, 255));
                write_reg(REG_DUMMY, $urandom_range(1, 31));
            end
            calm = (p == 4);
            while (items < 1400 + 120 * p)
            begin
                if (chance(10)) noise();
                else run_sequence(3'($urandom_range(2)));
            end
        end
        calm = 0;
        drain();
        repeat (20) @(negedge clk);

        $display("covered %0d sequences over %0d input beats, %0d result beats checked",
                 sequences, items, sb.checked);
        $display("random gaps and stalls, aborting starts, stray bytes and register rewrites");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS sd_spi_card_sequencer_core");
        else
            $display("FAIL sd_spi_card_sequencer_core");
        $finish;
    end
endmodule
